// ----- sv/dmbp_pkg.sv -----
// dmbp_pkg: shared constants, register indexes and controller/datapath types
// for the depth mask back-projection block.
// No dependencies.
package dmbp_pkg;

  // sampling limit per frame
  localparam int unsigned MaxSamples = 6000;

  // scaled depth band in Q.24 metres: 0.1 m .. 2.0 m
  localparam logic [39:0] ZLowQ24  = 40'd1677722;
  localparam logic [39:0] ZHighQ24 = 40'd33554432;

  // saturation limits of the counters
  localparam logic [12:0] Cnt13Max = 13'h1FFF;
  localparam logic [24:0] Cnt25Max = 25'h1FFFFFF;

  // rounding and saturation of projected coordinates
  localparam logic [58:0] RoundHalf = 59'd1 << 27;
  localparam logic [30:0] PosLimit  = 31'd8388607;
  localparam logic [30:0] NegLimit  = 31'd8388608;

  // configuration register indexes
  localparam logic [2:0] REG_DEPTH_SCALE  = 3'd0;
  localparam logic [2:0] REG_CENTER_X     = 3'd1;
  localparam logic [2:0] REG_CENTER_Y     = 3'd2;
  localparam logic [2:0] REG_INV_FOCAL_X  = 3'd3;
  localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd4;
  localparam logic [2:0] REG_SAMPLE_STEP  = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd7;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [23:0] depth_scale;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [11:0] sample_step;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } dmbp_cfg_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_in;   // capture input word, update frame counters
    logic mul_z;     // raw depth times scale
    logic eval;      // classify depth, update tallies, form offsets
    logic mul_dz;    // offset times depth
    logic mul_inv;   // times reciprocal focal length
    logic load_out;  // round, saturate, fill output register
  } dmbp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic keep;      // item in eval makes a point
    logic out_free;  // output register can take a word this cycle
  } dmbp_status_t;

endpackage

// ----- sv/dmbp_ctrl.sv -----
// dmbp_ctrl: sequencing state machine for one pixel word at a time.
// Depends on dmbp_pkg.
module dmbp_ctrl
  import dmbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  dmbp_status_t status,
  output dmbp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_Z   = 3'd1;
  localparam logic [2:0] ST_EVAL    = 3'd2;
  localparam logic [2:0] ST_MUL_DZ  = 3'd3;
  localparam logic [2:0] ST_MUL_INV = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL_Z;
        end
      end
      ST_MUL_Z: begin
        cmd.mul_z = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.keep ? ST_MUL_DZ : ST_DONE;
      end
      ST_MUL_DZ: begin
        cmd.mul_dz = 1'b1;
        state_nxt  = ST_MUL_INV;
      end
      ST_MUL_INV: begin
        cmd.mul_inv = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/dmbp_datapath.sv -----
// dmbp_datapath: frame counters, depth check, pinhole projection and the
// output register. Driven by dmbp_ctrl; depends on dmbp_pkg.
module dmbp_datapath
  import dmbp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  dmbp_cfg_t     cfg,
  input  dmbp_cmd_t     cmd,
  output dmbp_status_t  status,
  input  logic [39:0]   in_tdata,
  input  logic          in_tuser,
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);

  // round half away from zero, saturate to 24-bit two's complement
  function automatic logic [23:0] round_sat(input logic [57:0] prod, input logic neg);
    logic [58:0] sum;
    logic [30:0] q;
    sum = {1'b0, prod} + RoundHalf;
    q   = sum[58:28];
    if (neg) begin
      if (q > NegLimit) q = NegLimit;
      round_sat = 24'(~q + 31'd1);
    end else begin
      if (q > PosLimit) q = PosLimit;
      round_sat = q[23:0];
    end
  endfunction

  logic [11:0] in_px, in_py;
  logic [15:0] in_draw;

  // item registers
  logic [11:0] px_r, py_r;
  logic [15:0] draw_r;
  logic        last_r, take_r, keep_r;
  logic [39:0] zq_r;
  logic [17:0] z16_r;
  logic [15:0] magx_r, magy_r;
  logic        negx_r, negy_r;
  logic [33:0] dzx_r, dzy_r;
  logic [57:0] prodx_r, prody_r;

  // frame counters
  logic [11:0] phase_r;
  logic [12:0] taken_r, zero_r, range_r, point_r;
  logic [24:0] seen_r;

  // output register
  logic         out_valid_r;
  logic [135:0] out_data_r;
  logic [1:0]   out_user_r;
  logic         out_last_r;

  // accept-time signals
  logic [11:0] step;
  logic [11:0] phase_base;
  logic [12:0] taken_base;
  logic [24:0] seen_base;
  logic        sampled, in_frame;
  logic [12:0] phase_inc;

  // eval-time signals
  logic        no_reading, out_band;
  logic [39:0] zq_round;
  logic [15:0] p16x, p16y;

  assign in_px   = in_tdata[11:0];
  assign in_py   = in_tdata[23:12];
  assign in_draw = in_tdata[39:24];

  // sampling decision on the incoming word
  always_comb begin
    step       = (cfg.sample_step == 12'd0) ? 12'd1 : cfg.sample_step;
    phase_base = in_tuser ? 12'd0 : phase_r;
    taken_base = in_tuser ? 13'd0 : taken_r;
    seen_base  = in_tuser ? 25'd0 : seen_r;
    sampled    = (phase_base == 12'd0) && ({3'b000, taken_base} < 16'(MaxSamples));
    phase_inc  = {1'b0, phase_base} + 13'd1;
    in_frame   = ({1'b0, in_px} < cfg.frame_width) && ({1'b0, in_py} < cfg.frame_height);
  end

  // depth classification, pixel offsets and status
  always_comb begin
    no_reading      = (draw_r == 16'd0);
    out_band        = (zq_r < ZLowQ24) || (zq_r > ZHighQ24);
    status.keep     = take_r && !no_reading && !out_band;
    status.out_free = !out_valid_r || out_tready;
    zq_round        = zq_r + 40'd128;
    p16x            = {px_r, 4'b0000};
    p16y            = {py_r, 4'b0000};
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      taken_r <= '0;
      seen_r  <= '0;
      zero_r  <= '0;
      range_r <= '0;
      point_r <= '0;
    end else if (cmd.load_in) begin
      seen_r  <= (seen_base == Cnt25Max) ? seen_base : seen_base + 25'd1;
      phase_r <= (phase_inc >= {1'b0, step}) ? 12'd0 : phase_inc[11:0];
      if (sampled && taken_base != Cnt13Max) taken_r <= taken_base + 13'd1;
      else                                   taken_r <= taken_base;
      if (in_tuser) begin
        zero_r  <= '0;
        range_r <= '0;
        point_r <= '0;
      end
    end else if (cmd.eval && take_r) begin
      if (no_reading) begin
        if (zero_r != Cnt13Max) zero_r <= zero_r + 13'd1;
      end else if (out_band) begin
        if (range_r != Cnt13Max) range_r <= range_r + 13'd1;
      end else begin
        if (point_r != Cnt13Max) point_r <= point_r + 13'd1;
      end
    end
  end

  // item capture and arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px_r   <= in_px;
      py_r   <= in_py;
      draw_r <= in_draw;
      last_r <= in_tlast;
      take_r <= sampled && in_frame;
    end
    if (cmd.mul_z) begin
      zq_r <= 40'(draw_r * cfg.depth_scale);
    end
    if (cmd.eval) begin
      keep_r <= status.keep;
      z16_r  <= zq_round[25:8];
      negx_r <= p16x < cfg.center_x;
      negy_r <= p16y < cfg.center_y;
      magx_r <= (p16x < cfg.center_x) ? cfg.center_x - p16x : p16x - cfg.center_x;
      magy_r <= (p16y < cfg.center_y) ? cfg.center_y - p16y : p16y - cfg.center_y;
    end
    if (cmd.mul_dz) begin
      dzx_r <= 34'(magx_r * z16_r);
      dzy_r <= 34'(magy_r * z16_r);
    end
    if (cmd.mul_inv) begin
      prodx_r <= 58'(dzx_r * cfg.inv_focal_x);
      prody_r <= 58'(dzy_r * cfg.inv_focal_y);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r[23:0]    <= keep_r ? round_sat(prodx_r, negx_r) : 24'd0;
      out_data_r[47:24]   <= keep_r ? round_sat(prody_r, negy_r) : 24'd0;
      out_data_r[65:48]   <= keep_r ? z16_r : 18'd0;
      out_data_r[90:66]   <= seen_r;
      out_data_r[103:91]  <= zero_r;
      out_data_r[116:104] <= range_r;
      out_data_r[129:117] <= point_r;
      out_data_r[135:130] <= 6'd0;
      out_user_r[0]       <= keep_r;
      out_user_r[1]       <= last_r && (point_r != 13'd0);
      out_last_r          <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/depth_mask_to_point_backprojection_top.sv -----
// depth_mask_to_point_backprojection_top: configuration registers and the
// controller/datapath pair. Depends on dmbp_pkg, dmbp_ctrl, dmbp_datapath.
//
//  channel | direction | signals                       | contents
//  --------+-----------+-------------------------------+---------------------------
//  in_     | slave     | tvalid tready tdata tuser tlast| one mask pixel word
//  out_    | master    | tvalid tready tdata tuser tlast| one result word per pixel
//  cfg_    | slave     | valid ready addr data         | register writes, always ready
//
// A pixel word passes the depth multiply and the depth check; the chain of three registered
// multiplies (depth, offset, focal) is run in full only when a point is made.
// The next word is taken as soon as the result sits in the output register,
// even while that register waits on out_tready.
// Reset (rst_n low, synchronous) clears counters, control state and output valid, and sets configuration to defaults.
module depth_mask_to_point_backprojection_top
  import dmbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // pixel_x[11:0], pixel_y[23:12], depth_raw[39:24]
  input  logic         in_tuser,   // first_of_frame
  input  logic         in_tlast,   // last_of_frame
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // point_x[23:0], point_y[47:24], point_z[65:48],
                                   // pixel_count[90:66], zero_count[103:91],
                                   // out_of_range_count[116:104], valid_count[129:117]
  output logic [1:0]   out_tuser,  // point_valid[0], frame_ok[1]
  output logic         out_tlast,  // frame_done
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_data
);

  dmbp_cfg_t    cfg_r;
  dmbp_cmd_t    cmd;
  dmbp_status_t status;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_scale  <= 24'd16777;
      cfg_r.center_x     <= 16'd5120;
      cfg_r.center_y     <= 16'd3840;
      cfg_r.inv_focal_x  <= 24'd27962;
      cfg_r.inv_focal_y  <= 24'd27962;
      cfg_r.sample_step  <= 12'd1;
      cfg_r.frame_width  <= 13'd640;
      cfg_r.frame_height <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_DEPTH_SCALE:  cfg_r.depth_scale  <= cfg_data;
        REG_CENTER_X:     cfg_r.center_x     <= cfg_data[15:0];
        REG_CENTER_Y:     cfg_r.center_y     <= cfg_data[15:0];
        REG_INV_FOCAL_X:  cfg_r.inv_focal_x  <= cfg_data;
        REG_INV_FOCAL_Y:  cfg_r.inv_focal_y  <= cfg_data;
        REG_SAMPLE_STEP:  cfg_r.sample_step  <= cfg_data[11:0];
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  dmbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dmbp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
